// ----- src/mcas_pkg.sv -----
// shared constants, types and state encoding for the minimum-cost assignment solver
package mcas_pkg;

  localparam int N       = 4;
  localparam int IDX_W   = $clog2(N);
  localparam int CNT_W   = $clog2(N + 1);
  localparam int ADDR_W  = $clog2(N * N);
  localparam int COST_W  = 10;
  localparam int TOTAL_W = 12;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_INIT,
    ST_TRY,
    ST_EVAL,
    ST_OUT
  } mcas_state_t;

  typedef struct packed {
    logic load_wr;
    logic start;
    logic t_inc;
    logic descend;
    logic leaf_take;
    logic backtrack;
    logic out_start;
    logic out_next;
  } mcas_cmd_t;

  typedef struct packed {
    logic t_end;
    logic busy_t;
    logic lvl_zero;
    logic leaf;
    logic prune;
    logic out_last;
  } mcas_status_t;

endpackage

// ----- src/mcas_in_if.sv -----
// request channel carrying one cost matrix entry
interface mcas_in_if;
  import mcas_pkg::*;

  logic              valid;
  logic              ready;
  logic [IDX_W-1:0]  row_teacher;
  logic [IDX_W-1:0]  col_lesson;
  logic [COST_W-1:0] cost;
  logic              last_entry;

  modport source (output valid, output row_teacher, output col_lesson, output cost,
                  output last_entry, input ready);
  modport sink   (input valid, input row_teacher, input col_lesson, input cost,
                  input last_entry, output ready);
endinterface

// ----- src/mcas_out_if.sv -----
// result channel carrying one teacher row of the optimum
interface mcas_out_if;
  import mcas_pkg::*;

  logic               valid;
  logic               ready;
  logic [IDX_W-1:0]   teacher_index;
  logic [IDX_W-1:0]   assigned_lesson;
  logic [TOTAL_W-1:0] total_cost;
  logic               last_result;

  modport source (output valid, output teacher_index, output assigned_lesson,
                  output total_cost, output last_result, input ready);
  modport sink   (input valid, input teacher_index, input assigned_lesson,
                  input total_cost, input last_result, output ready);
endinterface

// ----- src/mcas_dp.sv -----
// datapath: cost memory, depth-first search registers and result formatting
module mcas_dp (
  input  logic                           clk,
  input  logic                           rst_n,
  input  mcas_pkg::mcas_cmd_t            cmd,
  input  logic [mcas_pkg::IDX_W-1:0]     wr_row,
  input  logic [mcas_pkg::IDX_W-1:0]     wr_col,
  input  logic [mcas_pkg::COST_W-1:0]    wr_cost,
  output mcas_pkg::mcas_status_t         status,
  output logic [mcas_pkg::IDX_W-1:0]     res_teacher,
  output logic [mcas_pkg::IDX_W-1:0]     res_lesson,
  output logic [mcas_pkg::TOTAL_W-1:0]   res_total,
  output logic                           res_last
);
  import mcas_pkg::*;

  logic [COST_W-1:0]  cost_mem [N*N];
  logic [COST_W-1:0]  rd_data_r;
  logic [ADDR_W-1:0]  rd_addr;
  logic [ADDR_W-1:0]  wr_addr;
  logic               wr_in_range;

  logic [IDX_W-1:0]   lvl_r, lvl_nxt;
  logic [CNT_W-1:0]   t_r, t_nxt;
  logic [N-1:0]       busy_r, busy_nxt;
  logic               have_best_r, have_best_nxt;
  logic [TOTAL_W-1:0] best_r, best_nxt;
  logic [IDX_W-1:0]   pick_r [N];
  logic [IDX_W-1:0]   pick_nxt [N];
  logic [IDX_W-1:0]   best_pick_r [N];
  logic [IDX_W-1:0]   best_pick_nxt [N];
  logic [TOTAL_W-1:0] acc_r [N];
  logic [TOTAL_W-1:0] acc_nxt [N];
  logic [IDX_W-1:0]   out_idx_r, out_idx_nxt;

  logic [IDX_W-1:0]   t_idx;
  logic [IDX_W-1:0]   prev_lvl;
  logic [IDX_W-1:0]   prev_pick;
  logic [TOTAL_W-1:0] sum;

  assign t_idx       = t_r[IDX_W-1:0];
  assign prev_lvl    = lvl_r - 1'b1;
  assign prev_pick   = pick_r[prev_lvl];
  assign rd_addr     = ADDR_W'(int'(t_idx) * N + int'(lvl_r));
  assign wr_addr     = ADDR_W'(int'(wr_row) * N + int'(wr_col));
  assign wr_in_range = (CNT_W'(wr_row) < CNT_W'(N)) && (CNT_W'(wr_col) < CNT_W'(N));
  assign sum         = acc_r[lvl_r] + TOTAL_W'(rd_data_r);

  // cost store, registered read
  always_ff @(posedge clk) begin
    if (cmd.load_wr && wr_in_range) begin
      cost_mem[wr_addr] <= wr_cost;
    end
    rd_data_r <= cost_mem[rd_addr];
  end

  always_comb begin
    status.t_end    = (t_r == CNT_W'(N));
    status.busy_t   = busy_r[t_idx];
    status.lvl_zero = (lvl_r == '0);
    status.leaf     = (lvl_r == IDX_W'(N - 1));
    status.prune    = have_best_r && (sum >= best_r);
    status.out_last = (out_idx_r == IDX_W'(N - 1));
  end

  always_comb begin
    lvl_nxt       = lvl_r;
    t_nxt         = t_r;
    busy_nxt      = busy_r;
    have_best_nxt = have_best_r;
    best_nxt      = best_r;
    pick_nxt      = pick_r;
    best_pick_nxt = best_pick_r;
    acc_nxt       = acc_r;
    out_idx_nxt   = out_idx_r;
    if (cmd.start) begin
      lvl_nxt       = '0;
      t_nxt         = '0;
      busy_nxt      = '0;
      have_best_nxt = 1'b0;
      acc_nxt[0]    = '0;
    end
    if (cmd.t_inc) begin
      t_nxt = t_r + 1'b1;
    end
    if (cmd.descend) begin
      busy_nxt[t_idx]             = 1'b1;
      pick_nxt[lvl_r]             = t_idx;
      acc_nxt[lvl_r + 1'b1]       = sum;
      lvl_nxt                     = lvl_r + 1'b1;
      t_nxt                       = '0;
    end
    if (cmd.leaf_take) begin
      best_nxt             = sum;
      have_best_nxt        = 1'b1;
      best_pick_nxt        = pick_r;
      best_pick_nxt[lvl_r] = t_idx;
      t_nxt                = t_r + 1'b1;
    end
    if (cmd.backtrack) begin
      lvl_nxt             = prev_lvl;
      busy_nxt[prev_pick] = 1'b0;
      t_nxt               = CNT_W'(prev_pick) + 1'b1;
    end
    if (cmd.out_start) begin
      out_idx_nxt = '0;
    end
    if (cmd.out_next) begin
      out_idx_nxt = out_idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lvl_r       <= '0;
      t_r         <= '0;
      busy_r      <= '0;
      have_best_r <= 1'b0;
      out_idx_r   <= '0;
    end else begin
      lvl_r       <= lvl_nxt;
      t_r         <= t_nxt;
      busy_r      <= busy_nxt;
      have_best_r <= have_best_nxt;
      out_idx_r   <= out_idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    best_r      <= best_nxt;
    pick_r      <= pick_nxt;
    best_pick_r <= best_pick_nxt;
    acc_r       <= acc_nxt;
  end

  // invert lesson->teacher map for the teacher being reported
  always_comb begin
    res_lesson = '0;
    for (int l = 0; l < N; l++) begin
      if (best_pick_r[l] == out_idx_r) begin
        res_lesson = IDX_W'(l);
      end
    end
  end

  assign res_teacher = out_idx_r;
  assign res_total   = best_r;
  assign res_last    = status.out_last;

  a_busy_depth : assert property (@(posedge clk) disable iff (!rst_n)
    $countones(busy_r) == int'(lvl_r))
    else $error("busy mask does not match search depth");

  a_t_range : assert property (@(posedge clk) disable iff (!rst_n)
    t_r <= CNT_W'(N))
    else $error("candidate teacher counter out of range");

  a_best_drops : assert property (@(posedge clk) disable iff (!rst_n)
    cmd.leaf_take && have_best_r |=> best_r < $past(best_r))
    else $error("new best assignment is not cheaper");

  a_start_clears : assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start |=> !have_best_r && busy_r == '0)
    else $error("search start left stale state");

endmodule

// ----- src/mcas_ctrl.sv -----
// controller: load, depth-first search sequencing and result handoff
module mcas_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic                   in_last,
  output logic                   in_ready,
  output logic                   out_valid,
  input  logic                   out_ready,
  input  mcas_pkg::mcas_status_t status,
  output mcas_pkg::mcas_cmd_t    cmd
);
  import mcas_pkg::*;

  mcas_state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_LOAD: begin
        if (in_valid && in_last) state_nxt = ST_INIT;
      end
      ST_INIT: state_nxt = ST_TRY;
      ST_TRY: begin
        if (status.t_end) begin
          if (status.lvl_zero) state_nxt = ST_OUT;
        end else if (!status.busy_t) begin
          state_nxt = ST_EVAL;
        end
      end
      ST_EVAL: state_nxt = ST_TRY;
      ST_OUT: begin
        if (out_ready && status.out_last) state_nxt = ST_LOAD;
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      ST_LOAD: begin
        in_ready    = 1'b1;
        cmd.load_wr = in_valid;
      end
      ST_INIT: cmd.start = 1'b1;
      ST_TRY: begin
        if (status.t_end) begin
          cmd.out_start = status.lvl_zero;
          cmd.backtrack = !status.lvl_zero;
        end else begin
          cmd.t_inc = status.busy_t;
        end
      end
      ST_EVAL: begin
        if (status.prune) begin
          cmd.t_inc = 1'b1;
        end else if (status.leaf) begin
          cmd.leaf_take = 1'b1;
        end else begin
          cmd.descend = 1'b1;
        end
      end
      ST_OUT: begin
        out_valid    = 1'b1;
        cmd.out_next = out_ready && !status.out_last;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_no_overlap : assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("request and result sides open at once");

  a_out_done : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && status.out_last |=> in_ready && !out_valid)
    else $error("block did not return to loading after last result");

endmodule

// ----- src/min_cost_assignment_solver.sv -----
// top level of the minimum-cost teacher/lesson assignment solver
// Matrix entries are taken one per cycle while loading and are written to a
// 16-entry cost memory. The request marked last_entry starts an exact
// depth-first branch-and-bound search that walks lessons in order and tries
// teachers in ascending order, keeping only strictly cheaper complete
// assignments, so ties resolve to the lexicographically first teacher per
// lesson. Each teacher tried takes a memory read state, then an add and
// bound compare state; a busy teacher is skipped, or a level unwound, in
// the read state alone. The cost memory has a single registered read port.
// A start state precedes the search. Four results then follow, one per
// teacher in order, one per cycle when the sink is ready. No request is
// taken from the last entry until the final result is delivered.
module min_cost_assignment_solver (
  input  logic        clk,
  input  logic        rst_n,
  mcas_in_if.sink     in_chan,
  mcas_out_if.source  out_chan
);
  import mcas_pkg::*;

  mcas_cmd_t    cmd;
  mcas_status_t status;
  logic         in_ready;
  logic         out_valid;

  mcas_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_last   (in_chan.last_entry),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_chan.ready),
    .status    (status),
    .cmd       (cmd)
  );

  mcas_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .wr_row      (in_chan.row_teacher),
    .wr_col      (in_chan.col_lesson),
    .wr_cost     (in_chan.cost),
    .status      (status),
    .res_teacher (out_chan.teacher_index),
    .res_lesson  (out_chan.assigned_lesson),
    .res_total   (out_chan.total_cost),
    .res_last    (out_chan.last_result)
  );

  assign in_chan.ready  = in_ready;
  assign out_chan.valid = out_valid;

endmodule

// ----- sim/tb.sv -----
// self-checking testbench for the minimum-cost teacher/lesson assignment solver
class assignment_scoreboard;
  typedef struct packed {
    logic [mcas_pkg::IDX_W-1:0]   teacher;
    logic [mcas_pkg::IDX_W-1:0]   lesson;
    logic [mcas_pkg::TOTAL_W-1:0] total;
    logic                         last;
  } teacher_row_t;

  logic [mcas_pkg::COST_W-1:0] cost_mem [mcas_pkg::N*mcas_pkg::N];
  teacher_row_t                expected_rows [$];
  int                          errors;
  int                          searches;
  int                          results;

  function void note_entry(logic [mcas_pkg::IDX_W-1:0] row, logic [mcas_pkg::IDX_W-1:0] col,
                           logic [mcas_pkg::COST_W-1:0] c, logic last);
    if (row < mcas_pkg::N && col < mcas_pkg::N) begin
      cost_mem[row*mcas_pkg::N+col] = c;
    end
    if (last) begin
      searches++;
      predict_assignment();
    end
  endfunction

  // walks every permutation, lesson 0 most significant, keeping only strictly cheaper ones
  function void predict_assignment();
    int                     best_total;
    bit                     found;
    int                     pick [mcas_pkg::N];
    int                     best_pick [mcas_pkg::N];
    int                     lesson_of [mcas_pkg::N];
    int                     rest;
    int                     sum;
    bit                     clash;
    bit [mcas_pkg::N-1:0]   used;
    teacher_row_t           row;
    found = 0;
    best_total = 0;
    for (int code = 0; code < mcas_pkg::N ** mcas_pkg::N; code++) begin
      rest = code;
      for (int l = mcas_pkg::N - 1; l >= 0; l--) begin
        pick[l] = rest % mcas_pkg::N;
        rest = rest / mcas_pkg::N;
      end
      used = '0;
      clash = 0;
      sum = 0;
      for (int l = 0; l < mcas_pkg::N; l++) begin
        if (used[pick[l]]) clash = 1;
        used[pick[l]] = 1'b1;
        sum += cost_mem[pick[l]*mcas_pkg::N+l];
      end
      if (!clash && (!found || sum < best_total)) begin
        found = 1;
        best_total = sum;
        best_pick = pick;
      end
    end
    for (int l = 0; l < mcas_pkg::N; l++) lesson_of[best_pick[l]] = l;
    if (best_total > 4095) best_total = 4095;
    for (int t = 0; t < mcas_pkg::N; t++) begin
      row.teacher = mcas_pkg::IDX_W'(t);
      row.lesson  = mcas_pkg::IDX_W'(lesson_of[t]);
      row.total   = mcas_pkg::TOTAL_W'(best_total);
      row.last    = (t == mcas_pkg::N - 1);
      expected_rows.push_back(row);
    end
  endfunction

  function void check_result(logic [mcas_pkg::IDX_W-1:0] teacher,
                             logic [mcas_pkg::IDX_W-1:0] lesson,
                             logic [mcas_pkg::TOTAL_W-1:0] total, logic last);
    teacher_row_t exp_row;
    results++;
    if (expected_rows.size() == 0) begin
      $display("%0t: unexpected result teacher %0d lesson %0d total %0d", $time,
               teacher, lesson, total);
      errors++;
      return;
    end
    exp_row = expected_rows.pop_front();
    if (teacher !== exp_row.teacher) begin
      $display("%0t: teacher_index expected %0d actual %0d", $time, exp_row.teacher, teacher);
      errors++;
    end
    if (lesson !== exp_row.lesson) begin
      $display("%0t: assigned_lesson expected %0d actual %0d", $time, exp_row.lesson, lesson);
      errors++;
    end
    if (total !== exp_row.total) begin
      $display("%0t: total_cost expected %0d actual %0d", $time, exp_row.total, total);
      errors++;
    end
    if (last !== exp_row.last) begin
      $display("%0t: last_result expected %0d actual %0d", $time, exp_row.last, last);
      errors++;
    end
  endfunction

  function int pending();
    return expected_rows.size();
  endfunction
endclass

module tb;
  import mcas_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_ITEMS = 140;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 250;

  logic clk;
  logic rst_n;

  mcas_in_if  in_if ();
  mcas_out_if out_if ();

  min_cost_assignment_solver dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  assignment_scoreboard sb = new();

  int cycles     = 0;
  int items_sent = 0;
  int snd_idle   = 0;
  int rcv_idle   = 0;
  bit hold_ask   = 0;
  bit hold_taken = 0;
  int hold_left  = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver side: random stalls plus one long hold-off
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_ask && !hold_taken) begin
        hold_taken = 1;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_if.ready <= 1'b0;
        hold_left--;
      end else begin
        out_if.ready <= ($urandom_range(99) >= rcv_idle);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (rst_n && out_if.valid && out_if.ready) begin
      sb.check_result(out_if.teacher_index, out_if.assigned_lesson, out_if.total_cost,
                      out_if.last_result);
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("min_cost_assignment_solver regression: fail");
      $finish;
    end
  end

  task automatic send_entry(input logic [IDX_W-1:0] row, input logic [IDX_W-1:0] col,
                            input logic [COST_W-1:0] c, input logic last);
    while ($urandom_range(99) < snd_idle) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid       <= 1'b1;
    in_if.row_teacher <= row;
    in_if.col_lesson  <= col;
    in_if.cost        <= c;
    in_if.last_entry  <= last;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    sb.note_entry(row, col, c, last);
    items_sent++;
    @(negedge clk);
  endtask

  // small values give plenty of equal-cost optima
  function automatic logic [COST_W-1:0] draw_cost();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2:       return COST_W'($urandom_range(999, 1023));
      3, 4, 5: return COST_W'($urandom_range(7));
      default: return COST_W'($urandom_range(1023));
    endcase
  endfunction

  task automatic load_matrix(input bit all_max);
    int order [N*N];
    int j;
    int tmp;
    for (int i = 0; i < N*N; i++) order[i] = i;
    for (int i = N*N - 1; i > 0; i--) begin
      j = $urandom_range(i);
      tmp = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    for (int i = 0; i < N*N; i++) begin
      send_entry(IDX_W'(order[i] / N), IDX_W'(order[i] % N), all_max ? '1 : draw_cost(),
                 i == N*N - 1);
    end
  endtask

  task automatic update_entries(input int count);
    for (int i = 0; i < count; i++) begin
      send_entry(IDX_W'($urandom_range(N-1)), IDX_W'($urandom_range(N-1)), draw_cost(),
                 i == count - 1);
    end
  endtask

  initial begin
    int directed_items;
    rst_n             = 1'b0;
    in_if.valid       = 1'b0;
    in_if.row_teacher = '0;
    in_if.col_lesson  = '0;
    in_if.cost        = '0;
    in_if.last_entry  = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // diagonal at maximum, everything else free: many tied optima
    for (int t = 0; t < N; t++) begin
      for (int l = 0; l < N; l++) begin
        send_entry(IDX_W'(t), IDX_W'(l), (t == l) ? 10'd1023 : 10'd0,
                   t == N-1 && l == N-1);
      end
    end
    send_entry(2'd0, 2'd1, 10'd1023, 1'b1);
    send_entry(2'd2, 2'd3, 10'd341, 1'b1);
    send_entry(2'd3, 2'd2, 10'd682, 1'b1);
    send_entry(2'd1, 2'd1, 10'd999, 1'b1);
    send_entry(2'd3, 2'd0, 10'd0, 1'b1);
    directed_items = items_sent;

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          snd_idle = 15;
          rcv_idle = 51;
        end
        1: begin
          snd_idle = 51;
          rcv_idle = 15;
        end
        default: begin
          snd_idle = 0;
          rcv_idle = 0;
          hold_ask = 1;
        end
      endcase
      while (items_sent < directed_items + (ph + 1) * RANDOM_ITEMS / 3) begin
        if ($urandom_range(3) == 0) load_matrix($urandom_range(3) == 0);
        else update_entries($urandom_range(1, 5));
      end
    end
    in_if.valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d matrix entries and %0d searches, %0d teacher rows checked",
             items_sent, sb.searches, sb.results);
    if (sb.errors == 0) begin
      $display("min_cost_assignment_solver regression: pass");
    end else begin
      $display("min_cost_assignment_solver regression: fail");
    end
    $finish;
  end
endmodule
